### rtl/core/iis_pkg.sv
// Shared sizes, widths and register indexes of the integral image stream unit.
// No dependencies; used by integral_image_stream_unit.
package iis_pkg;

  // Image limits and pixel width
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int PIXEL_BITS = 8;

  // Derived widths
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
  localparam int ROW_SUM_BITS = PIXEL_BITS + COL_BITS;
  localparam int SUM_BITS     = 20;
  localparam int SIZE_BITS    = 7;
  localparam int CFG_IDX_BITS = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

endpackage

### rtl/core/iis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns the old contents when the same entry is written.
module iis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/integral_image_stream_unit.sv
// Streaming integral image (summed-area table) unit, top level.
// Depends on iis_pkg and iis_ram (line store of the previous row).
//
// Pixels enter one per transfer in raster order; each one yields one
// result: the sum of all pixels of the frame above and left of it,
// inclusive, plus row-end and frame-end flags. The unit takes one pixel
// per clock while the output is not stalled; a result goes through the
// stage 1 register (line store read on the transfer edge) and is then
// added and written into the output register once the output slot is
// free or drains. A stalled output holds one more pixel in the read
// stage, then drops in_ready.
// Row and column counting and frame wrap are internal. Width and height come
// from the cfg_ write port (0 means 1, values above the maximum saturate).
// The user must write them only while idle; the unit does not enforce it.
// No clearing pass is needed after reset: line store entries carry valid bits.
module integral_image_stream_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [iis_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [iis_pkg::SIZE_BITS-1:0]     cfg_wr_data,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [iis_pkg::PIXEL_BITS-1:0]    in_pixel,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [iis_pkg::SUM_BITS-1:0]      out_area_sum,
  output logic                              out_row_end,
  output logic                              out_frame_end
);

  localparam int COL_BITS  = iis_pkg::COL_BITS;
  localparam int ROW_BITS  = iis_pkg::ROW_BITS;
  localparam int RSUM_BITS = iis_pkg::ROW_SUM_BITS;
  localparam int SUM_BITS  = iis_pkg::SUM_BITS;
  localparam int SIZE_BITS = iis_pkg::SIZE_BITS;
  localparam int MAX_W     = iis_pkg::MAX_WIDTH;

  // Configuration registers
  logic [SIZE_BITS-1:0] line_width_r;
  logic [SIZE_BITS-1:0] frame_height_r;

  // Stage 0 state: counters and running row sum
  logic [COL_BITS-1:0]  col_r, col_nxt;
  logic [ROW_BITS-1:0]  row_r, row_nxt;
  logic [RSUM_BITS-1:0] row_sum_r, row_sum_nxt;
  logic [MAX_W-1:0]     entry_valid_r;

  // Stage 1: line store read in flight
  logic                 s1_valid_r;
  logic [COL_BITS-1:0]  s1_col_r;
  logic [RSUM_BITS-1:0] s1_row_sum_r;
  logic                 s1_use_above_r;
  logic                 s1_row_end_r;
  logic                 s1_frame_end_r;
  logic                 fwd_r;
  logic [SUM_BITS-1:0]  fwd_data_r;

  // Output register
  logic                 out_valid_r;
  logic [SUM_BITS-1:0]  out_area_sum_r;
  logic                 out_row_end_r;
  logic                 out_frame_end_r;

  logic                 in_fire;
  logic                 s1_adv;
  logic [COL_BITS-1:0]  last_col;
  logic [ROW_BITS-1:0]  last_row;
  logic                 row_end;
  logic                 frame_end;
  logic                 fwd_hit;
  logic [SUM_BITS-1:0]  rd_data;
  logic [SUM_BITS-1:0]  above;
  logic [SUM_BITS-1:0]  s1_sum;

  // Handshake: stage 1 moves when the output slot is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Clamp sizes to last column and last row index
  always_comb begin
    if (line_width_r == '0) begin
      last_col = '0;
    end else if (line_width_r > SIZE_BITS'(MAX_W)) begin
      last_col = COL_BITS'(MAX_W - 1);
    end else begin
      last_col = COL_BITS'(line_width_r - SIZE_BITS'(1));
    end
    if (frame_height_r == '0) begin
      last_row = '0;
    end else if (frame_height_r > SIZE_BITS'(iis_pkg::MAX_HEIGHT)) begin
      last_row = ROW_BITS'(iis_pkg::MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_BITS'(frame_height_r - SIZE_BITS'(1));
    end
  end

  // Position flags and next counter values
  always_comb begin
    row_end   = col_r >= last_col;
    frame_end = row_end && (row_r >= last_row);
    if (col_r == '0) begin
      row_sum_nxt = RSUM_BITS'(in_pixel);
    end else begin
      row_sum_nxt = row_sum_r + RSUM_BITS'(in_pixel);
    end
    if (row_end) begin
      col_nxt = '0;
      row_nxt = frame_end ? '0 : row_r + ROW_BITS'(1);
    end else begin
      col_nxt = col_r + COL_BITS'(1);
      row_nxt = row_r;
    end
  end

  // Same column written back in the cycle it is read again
  assign fwd_hit = s1_adv && (s1_col_r == col_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= SIZE_BITS'(4);
      frame_height_r <= SIZE_BITS'(4);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        iis_pkg::CFG_LINE_WIDTH:   line_width_r   <= cfg_wr_data;
        iis_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Stage 0: advance counters on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      row_sum_r <= '0;
    end else if (in_fire) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      row_sum_r <= row_end ? '0 : row_sum_nxt;
    end
  end

  // Mark line store entries once written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (s1_adv) begin
      entry_valid_r[s1_col_r] <= 1'b1;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload, held while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r       <= col_r;
      s1_row_sum_r   <= row_sum_nxt;
      s1_use_above_r <= (row_r != '0) && (entry_valid_r[col_r] || fwd_hit);
      s1_row_end_r   <= row_end;
      s1_frame_end_r <= frame_end;
      fwd_r          <= fwd_hit;
      fwd_data_r     <= s1_sum;
    end
  end

  // Line store of the previous row's integral values
  iis_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (MAX_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (s1_sum),
    .rd_en   (in_fire),
    .rd_addr (col_r),
    .rd_data (rd_data)
  );

  // Add row sum to the value above
  always_comb begin
    if (!s1_use_above_r) begin
      above = '0;
    end else if (fwd_r) begin
      above = fwd_data_r;
    end else begin
      above = rd_data;
    end
    s1_sum = SUM_BITS'(s1_row_sum_r) + above;
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_area_sum_r  <= s1_sum;
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_area_sum  = out_area_sum_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

### sim/tb_top.sv
// Self-checking testbench for integral_image_stream_unit.
// Depends on iis_pkg and the unit's RTL; predicts every summed-area value
// and its row/frame flags, with random bursts on input and stalls on output.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [iis_pkg::SUM_BITS-1:0] area_sum;
    logic                         row_end;
    logic                         frame_end;
  } area_result_t;

  // DUT connections; inputs at known values from time zero
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  iis_pkg::cfg_idx_t              cfg_index = iis_pkg::CFG_LINE_WIDTH;
  logic [iis_pkg::SIZE_BITS-1:0]  cfg_wr_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [iis_pkg::PIXEL_BITS-1:0] in_pixel = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [iis_pkg::SUM_BITS-1:0]   out_area_sum;
  logic                           out_row_end;
  logic                           out_frame_end;

  // Predictor state: register copies, counters, row sum and line store
  logic [iis_pkg::SIZE_BITS-1:0]  line_width = 7'd4;
  logic [iis_pkg::SIZE_BITS-1:0]  frame_height = 7'd4;
  int unsigned                    col_pos = 0;
  int unsigned                    row_pos = 0;
  logic [31:0]                    run_sum = '0;
  logic [iis_pkg::SUM_BITS-1:0]   line_store [iis_pkg::MAX_WIDTH] = '{default: '0};

  area_result_t                   expected_q [$];
  int unsigned                    mismatches = 0;
  int unsigned                    pixels_sent = 0;
  int unsigned                    row_ends_seen = 0;
  int unsigned                    frame_ends_seen = 0;
  int unsigned                    reg_writes = 0;
  int unsigned                    burst_left = 0;

  // Receiver stall pattern state
  int unsigned                    stall_mode = 0;
  int unsigned                    mode_left = 0;
  int unsigned                    hold_left = 0;
  logic                           hold_on = 1'b1;

  integral_image_stream_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_area_sum  (out_area_sum),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Zero means one, anything above the maximum saturates
  function automatic int unsigned eff_size(logic [iis_pkg::SIZE_BITS-1:0] v,
                                           int unsigned max_v);
    if (v == '0) return 1;
    if (32'(v) > max_v) return max_v;
    return 32'(v);
  endfunction

  // Advance the summed-area predictor by one pixel
  function automatic area_result_t integrate_pixel(logic [iis_pkg::PIXEL_BITS-1:0] px);
    int unsigned                  w;
    int unsigned                  h;
    int unsigned                  col;
    logic [iis_pkg::SUM_BITS-1:0] above;
    area_result_t                 r;
    w = eff_size(line_width, iis_pkg::MAX_WIDTH);
    h = eff_size(frame_height, iis_pkg::MAX_HEIGHT);
    col = (col_pos >= iis_pkg::MAX_WIDTH) ? iis_pkg::MAX_WIDTH - 1 : col_pos;
    run_sum = (col == 0) ? 32'(px) : run_sum + 32'(px);
    above = (row_pos != 0) ? line_store[col] : '0;
    r.area_sum = iis_pkg::SUM_BITS'(run_sum + 32'(above));
    line_store[col] = r.area_sum;
    r.row_end = (col >= w - 1);
    r.frame_end = r.row_end && (row_pos >= h - 1);
    if (r.row_end) begin
      col_pos = 0;
      run_sum = '0;
      row_pos = r.frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col + 1;
    end
    return r;
  endfunction

  // Transfer one pixel, opening a new burst after a random gap when due
  task automatic send_pixel(logic [iis_pkg::PIXEL_BITS-1:0] px);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(integrate_pixel(px));
    burst_left--;
    pixels_sent++;
  endtask

  // Drop valid and hold until every result is back and the pipe is empty
  task automatic drain_to_idle();
    if (in_valid) in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(iis_pkg::cfg_idx_t idx, logic [iis_pkg::SIZE_BITS-1:0] val);
    drain_to_idle();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == iis_pkg::CFG_LINE_WIDTH) line_width = val;
    else frame_height = val;
    reg_writes++;
  endtask

  function automatic logic [iis_pkg::SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return iis_pkg::SIZE_BITS'(iis_pkg::MAX_WIDTH);
      2:       return iis_pkg::SIZE_BITS'($urandom_range(iis_pkg::MAX_WIDTH + 1, 127));
      3:       return iis_pkg::SIZE_BITS'($urandom_range(9, iis_pkg::MAX_WIDTH - 1));
      default: return iis_pkg::SIZE_BITS'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [iis_pkg::PIXEL_BITS-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return iis_pkg::PIXEL_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // Reset-default 4x4 frame with extreme and alternating pixel values
  task automatic test_default_frame();
    logic [iis_pkg::PIXEL_BITS-1:0] pattern [4] = '{8'hFF, 8'h00, 8'hAA, 8'h55};
    for (int i = 0; i < 16; i++) send_pixel(pattern[(i + i / 4) % 4]);
  endtask

  // Zero sizes act as a 1x1 frame: every pixel ends its row and frame
  task automatic test_zero_sizes();
    write_reg(iis_pkg::CFG_LINE_WIDTH, '0);
    write_reg(iis_pkg::CFG_FRAME_HEIGHT, '0);
    send_pixel(8'hFF);
    send_pixel(8'h7E);
  endtask

  // Saturated sizes, then shrink width and height in mid-frame
  task automatic test_saturate_and_shrink();
    write_reg(iis_pkg::CFG_LINE_WIDTH, '1);
    write_reg(iis_pkg::CFG_FRAME_HEIGHT, '1);
    repeat (3) send_pixel(8'hFF);
    write_reg(iis_pkg::CFG_LINE_WIDTH, 7'd2);
    send_pixel(8'h01);
    send_pixel(8'h80);
    write_reg(iis_pkg::CFG_FRAME_HEIGHT, 7'd1);
    send_pixel(8'hFF);
    send_pixel(8'h00);
  endtask

  // Mostly whole frames at random sizes, some cut short mid-frame
  task automatic test_random_frames();
    int unsigned n_done;
    int unsigned n;
    int unsigned area;
    n_done = 0;
    while (n_done < 1300) begin
      write_reg(iis_pkg::CFG_LINE_WIDTH, pick_size());
      if ($urandom_range(0, 3) != 0) write_reg(iis_pkg::CFG_FRAME_HEIGHT, pick_size());
      area = eff_size(line_width, iis_pkg::MAX_WIDTH) *
             eff_size(frame_height, iis_pkg::MAX_HEIGHT);
      n = (area <= 96) ? $urandom_range(1, 4) * area : $urandom_range(16, 160);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 5);
      repeat (n) send_pixel(pick_pixel());
      n_done += n;
    end
  endtask

  // Check each result transfer and advance the output stall pattern
  always @(posedge clk) begin : result_check
    area_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual area_sum %0d",
                 $time, out_area_sum);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_row_end) row_ends_seen++;
        if (out_frame_end) frame_ends_seen++;
        if (out_area_sum !== exp_r.area_sum || out_row_end !== exp_r.row_end ||
            out_frame_end !== exp_r.frame_end) begin
          mismatches++;
          if (out_area_sum !== exp_r.area_sum)
            $display("%0t: area_sum expected %0d actual %0d",
                     $time, exp_r.area_sum, out_area_sum);
          if (out_row_end !== exp_r.row_end)
            $display("%0t: row_end expected %0b actual %0b",
                     $time, exp_r.row_end, out_row_end);
          if (out_frame_end !== exp_r.frame_end)
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, exp_r.frame_end, out_frame_end);
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left == 0) begin
          hold_on = ~hold_on;
          hold_left = hold_on ? $urandom_range(1, 10) : $urandom_range(1, 20);
        end
        hold_left--;
        out_ready <= hold_on;
      end
    endcase
  end

  initial begin
    int unsigned waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frame();
    test_zero_sizes();
    test_saturate_and_shrink();
    test_random_frames();

    // Wait for the last results, then let the pipe settle
    if (in_valid) in_valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_q.size() != 0) begin
      mismatches += expected_q.size();
      $display("%0t: %0d results never arrived", $time, expected_q.size());
    end

    $display("tb: %0d pixels, %0d row ends, %0d frame ends checked", pixels_sent,
             row_ends_seen, frame_ends_seen);
    $display("tb: %0d register writes incl. zero, saturated and mid-frame sizes",
             reg_writes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
